// File: hw/rtl/lbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants, types and register indexes for the 3x3 LBP pixel coder.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int MaxLinePixels = 2048;
   localparam int MaxLines      = 4096;
   localparam int MinFrameDim   = 3;

   localparam int PixelW  = 8;
   localparam int CodeW   = 8;
   localparam int ColW    = $clog2(MaxLinePixels);   // column counter, line store address
   localparam int RowW    = $clog2(MaxLines);        // row counter
   localparam int WidthW  = 12;                      // frame_width register
   localparam int HeightW = 13;                      // frame_height register
   localparam int CsrDataW = (WidthW > HeightW) ? WidthW : HeightW;

   localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
   localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Position of one request within the frame, after frame_start is applied
   typedef struct packed {
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            emit;   // window complete, a code is produced
      logic            last;   // last interior centre of the frame
   } pos_type;

endpackage

// File: hw/rtl/lbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_req_if / lbp_rsp_if
// Valid/ready stream channels for pixel requests and pattern code results.
// ----------------------------------------------------------------------------
interface lbp_req_if;
   import lbp_pkg::*;
   logic              valid;
   logic              ready;
   logic [PixelW-1:0] pixel;
   logic              frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp_rsp_if;
   import lbp_pkg::*;
   logic                valid;
   logic                ready;
   logic [CodeW-1:0]    pattern_code;
   logic [RowW-1:0]     centre_row;
   logic [ColW-1:0]     centre_col;
   logic                frame_last;

   modport source (output valid, output pattern_code, output centre_row,
                   output centre_col, output frame_last, input ready);
   modport sink   (input valid, input pattern_code, input centre_row,
                   input centre_col, input frame_last, output ready);
endinterface

// File: hw/rtl/lbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbp_ram #(
   parameter int Width = 8,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/lbp_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pos
// Raster position counters with size clamping and border detection.
// ----------------------------------------------------------------------------
module lbp_pos (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          frame_start,
   input  logic [lbp_pkg::WidthW-1:0]    frame_width,
   input  logic [lbp_pkg::HeightW-1:0]   frame_height,
   output lbp_pkg::pos_type              pos,
   output logic [lbp_pkg::WidthW-1:0]    width_eff
);
   import lbp_pkg::*;

   logic [ColW-1:0]    col_ff, col_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [HeightW-1:0] height_eff;
   logic [ColW-1:0]    col_cur;
   logic [RowW-1:0]    row_cur;
   logic [ColW:0]      col_inc;
   logic [RowW:0]      row_inc;

   // clamp sizes to the supported range
   always_comb begin
      width_eff = frame_width;
      if (frame_width < WidthW'(MinFrameDim))   width_eff = WidthW'(MinFrameDim);
      if (frame_width > WidthW'(MaxLinePixels)) width_eff = WidthW'(MaxLinePixels);
      height_eff = frame_height;
      if (frame_height < HeightW'(MinFrameDim)) height_eff = HeightW'(MinFrameDim);
      if (frame_height > HeightW'(MaxLines))    height_eff = HeightW'(MaxLines);
   end

   always_comb begin
      col_cur  = frame_start ? '0 : col_ff;
      row_cur  = frame_start ? '0 : row_ff;
      col_inc  = {1'b0, col_cur} + 1'b1;
      row_inc  = {1'b0, row_cur} + 1'b1;

      pos.col  = col_cur;
      pos.row  = row_cur;
      pos.emit = (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
      pos.last = (HeightW'(row_inc) == height_eff) && (WidthW'(col_inc) == width_eff);

      col_in = col_cur;
      row_in = row_cur;
      if (accept) begin
         if (WidthW'(col_inc) >= width_eff) begin
            col_in = '0;
            row_in = (HeightW'(row_inc) >= height_eff) ? '0 : row_inc[RowW-1:0];
         end else begin
            col_in = col_inc[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: hw/rtl/lbp_win.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_win
// 3x2 window registers and the eight-neighbour compare into an LBP code.
// ----------------------------------------------------------------------------
module lbp_win (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [lbp_pkg::PixelW-1:0]   up,
   input  logic [lbp_pkg::PixelW-1:0]   mid,
   input  logic [lbp_pkg::PixelW-1:0]   pix,
   output logic [lbp_pkg::CodeW-1:0]    code
);
   import lbp_pkg::*;

   // [0] upper c-2, [1] upper c-1, [2] middle c-2, [3] centre,
   // [4] lower c-2, [5] lower c-1
   logic [PixelW-1:0] win_ff [6];
   logic [PixelW-1:0] centre;

   always_comb begin
      centre  = win_ff[3];
      code[0] = win_ff[0] >= centre;
      code[1] = win_ff[1] >= centre;
      code[2] = up        >= centre;
      code[3] = mid       >= centre;
      code[4] = pix       >= centre;
      code[5] = win_ff[5] >= centre;
      code[6] = win_ff[4] >= centre;
      code[7] = win_ff[2] >= centre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= up;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= pix;
      end
   end

endmodule

// File: hw/rtl/lbp_3x3_pixel_coder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_3x3_pixel_coder
// 3x3 local binary pattern coder over a raster pixel stream, two line stores.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  req_if  | in  | valid / ready    | pixel[7:0], frame_start
//  rsp_if  | out | valid / ready    | pattern_code[7:0], centre_row[11:0],
//          |     |                  | centre_col[10:0], frame_last
//  csr_*   | in  | csr_we           | csr_index (0 width, 1 height), csr_wdata
//
//  One request per cycle while no stalled result holds stage 1; a code passes
//  through the line store read, then the window compare into the result register.
//  Line store read and write use separate column addresses, one port each.
//  Synchronous reset clears counters, window and valids; line stores are not
//  cleared. A stalled result holds stage 1 only while stage 1 carries a code;
//  border pixels drain through even when the result register is full.
// ----------------------------------------------------------------------------
module lbp_3x3_pixel_coder (
   input  logic                          clock,
   input  logic                          reset,
   lbp_req_if.sink                       req_if,
   lbp_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  lbp_pkg::csr_index_type        csr_index,
   input  logic [lbp_pkg::CsrDataW-1:0]  csr_wdata
);
   import lbp_pkg::*;

   // configuration
   logic [WidthW-1:0]  frame_width_ff;
   logic [HeightW-1:0] frame_height_ff;

   // request side
   logic              req_accept;
   pos_type           req_pos;
   logic [WidthW-1:0] width_eff;

   // stage 1: line store data valid, window compare
   logic              s1_valid_ff, s1_valid_in;
   logic [PixelW-1:0] s1_pixel_ff;
   pos_type           s1_pos_ff;
   logic              s1_byp_ff, s1_byp_in;    // read collided with a write
   logic [PixelW-1:0] s1_byp_up_ff, s1_byp_mid_ff;
   logic              s1_fire;
   logic [PixelW-1:0] ram_up, ram_mid, up_eff, mid_eff;
   logic [CodeW-1:0]  code;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [CodeW-1:0]  out_code_ff;
   logic [RowW-1:0]   out_row_ff;
   logic [ColW-1:0]   out_col_ff;
   logic              out_last_ff;
   logic              out_free;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WidthReset;
         frame_height_ff <= HeightReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[WidthW-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HeightW-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- handshake
   assign out_free     = !out_valid_ff || rsp_if.ready;
   // border pixels need no slot in the result register
   assign s1_fire      = s1_valid_ff && (out_free || !s1_pos_ff.emit);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_accept   = req_if.valid && req_if.ready;

   lbp_pos u_pos (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .frame_start  (req_if.frame_start),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .pos          (req_pos),
      .width_eff    (width_eff)
   );

   // ------------------------------------------------------------ line stores
   // Read at accept, write back when stage 1 retires. The only same-cycle
   // hit on one address is a frame restart at column zero right after
   // column zero; that case takes the retiring data instead of the RAM.
   lbp_ram #(.Width(PixelW), .Depth(MaxLinePixels)) u_ram_upper (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_pos_ff.col),
      .wdata (mid_eff),
      .re    (req_accept),
      .raddr (req_pos.col),
      .rdata (ram_up)
   );

   lbp_ram #(.Width(PixelW), .Depth(MaxLinePixels)) u_ram_middle (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_pos_ff.col),
      .wdata (s1_pixel_ff),
      .re    (req_accept),
      .raddr (req_pos.col),
      .rdata (ram_mid)
   );

   assign up_eff  = s1_byp_ff ? s1_byp_up_ff  : ram_up;
   assign mid_eff = s1_byp_ff ? s1_byp_mid_ff : ram_mid;

   // ---------------------------------------------------------------- stage 1
   assign s1_byp_in   = s1_fire && (s1_pos_ff.col == req_pos.col);
   assign s1_valid_in = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff   <= req_if.pixel;
         s1_pos_ff     <= req_pos;
         s1_byp_ff     <= s1_byp_in;
         s1_byp_up_ff  <= mid_eff;
         s1_byp_mid_ff <= s1_pixel_ff;
      end
   end

   lbp_win u_win (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_fire),
      .up      (up_eff),
      .mid     (mid_eff),
      .pix     (s1_pixel_ff),
      .code    (code)
   );

   // -------------------------------------------------------- result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_fire && s1_pos_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_pos_ff.emit) begin
         out_code_ff <= code;
         out_row_ff  <= s1_pos_ff.row - 1'b1;
         out_col_ff  <= s1_pos_ff.col - 1'b1;
         out_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.pattern_code = out_code_ff;
   assign rsp_if.centre_row   = out_row_ff;
   assign rsp_if.centre_col   = out_col_ff;
   assign rsp_if.frame_last   = out_last_ff;

   // ------------------------------------------------------------- assertions
   // a coded centre never lies on the top or left border
   a_centre_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.centre_row != '0) && (rsp_if.centre_col != '0))
      else $error("centre on border");

   // a read/write collision only comes from a restart at column zero
   a_bypass_col0: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_byp_in) |-> (req_if.frame_start && (req_pos.col == '0)))
      else $error("unexpected line store collision");

   // the last code of a frame sits one column left of the last column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_pos_ff.emit && s1_pos_ff.last) |=>
         (WidthW'(rsp_if.centre_col) == width_eff - WidthW'(2)))
      else $error("frame_last on wrong column");

   // a result waiting on a stall is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready) |-> !(s1_fire && s1_pos_ff.emit))
      else $error("pending result overwritten");

endmodule
